/* rtl/mtpa_pkg.sv */
`default_nettype none

package mtpa_pkg;

    // Partition limits
    localparam int unsigned MAX_PARTITIONS  = 16;
    localparam int unsigned CLAMSHELL_COUNT = 8;
    localparam int unsigned CLAMSHELL_LIMIT =
        (CLAMSHELL_COUNT < MAX_PARTITIONS) ? CLAMSHELL_COUNT : MAX_PARTITIONS;

    // Field widths
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned TEMP_W  = 17;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned TOPO_W  = 2;
    localparam int unsigned LIMIT_W = 7;

    // Word decode constants
    localparam logic [WORD_W-1:0] POISON_MASK  = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] POISON_VALUE = 32'hBADF_0000;
    localparam logic [WORD_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [7:0]        CODE_MIN     = 8'd21;
    localparam logic [7:0]        CODE_MAX     = 8'd80;
    localparam logic [7:0]        CODE_OFFSET  = 8'd20;
    localparam logic [TEMP_W-1:0] MDEG_PER_STEP = 17'd2000;
    localparam int unsigned       VALID_SHIFT  = 24;

    // Slot counts per topology
    localparam logic [COUNT_W-1:0] SLOTS_PAIRED = 3'd2;
    localparam logic [COUNT_W-1:0] SLOTS_FULL   = 3'd4;

    // Topology codes
    typedef enum logic [TOPO_W-1:0] {
        TOPO_UNKNOWN   = 2'd0,
        TOPO_STANDARD  = 2'd1,
        TOPO_CLAMSHELL = 2'd2,
        TOPO_RESERVED  = 2'd3
    } topo_t;

    typedef struct packed {
        logic              vld;
        logic [TEMP_W-1:0] temp;
    } slot_t;

    // Word is not all ones and not poisoned
    function automatic logic word_usable(input logic [WORD_W-1:0] w);
        word_usable = (w != ALL_ONES) && ((w & POISON_MASK) != POISON_VALUE);
    endfunction

    // Decode one data word; invalid words read as zero millidegrees
    function automatic slot_t decode_word(input logic            vbit,
                                          input logic [WORD_W-1:0] w);
        logic [7:0]        code;
        logic [TEMP_W-1:0] offs;
        slot_t             s;
        code   = w[23:16];
        offs   = TEMP_W'(code - CODE_OFFSET);
        s.vld  = vbit && word_usable(w) && (code >= CODE_MIN) && (code <= CODE_MAX);
        s.temp = s.vld ? TEMP_W'(offs * MDEG_PER_STEP) : '0;
        decode_word = s;
    endfunction

    // Pair of slots by maximum; ties keep the first word
    function automatic slot_t pair_max(input slot_t a, input slot_t b);
        slot_t s;
        if (a.vld && (!b.vld || a.temp >= b.temp))
            s = a;
        else if (b.vld)
            s = b;
        else
            s = '0;
        pair_max = s;
    endfunction

    function automatic logic [TEMP_W-1:0] max2(input logic [TEMP_W-1:0] a,
                                              input logic [TEMP_W-1:0] b);
        max2 = (b > a) ? b : a;
    endfunction

endpackage

`default_nettype wire

/* rtl/memory_thermal_partition_aggregator_unit.sv */
`default_nettype none

// Memory partition thermal aggregator. Each transfer on the input channel
// carries one partition (validity word plus four raw temperature words) and
// produces exactly one result: the decoded slot temperatures, their valid
// mask, the slot base/count for the configured topology, and the running
// hottest temperature of the current pass (cleared by first_of_pass). The
// unit takes one partition per clock while the output is not stalled: an input
// register feeds a single level of decode and max logic into the result
// register, and the running hottest value is updated in the same cycle a
// partition moves into the result register. A result is valid once it has passed
// the input register and the result register. A stalled result holds the result
// register and a full input register, and stalls the input in the same cycle.
// The topology register may only be written while no partition is in flight.

module memory_thermal_partition_aggregator_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // Configuration
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mtpa_pkg::TOPO_W-1:0]    topology,

    // Partition input
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mtpa_pkg::IDX_W-1:0]     partition_index,
    input  wire logic [mtpa_pkg::WORD_W-1:0]    validity_word,
    input  wire logic [mtpa_pkg::WORD_W-1:0]    data_word_0,
    input  wire logic [mtpa_pkg::WORD_W-1:0]    data_word_1,
    input  wire logic [mtpa_pkg::WORD_W-1:0]    data_word_2,
    input  wire logic [mtpa_pkg::WORD_W-1:0]    data_word_3,
    input  wire logic                           first_of_pass,

    // Result output
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [mtpa_pkg::BASE_W-1:0]         slot_base,
    output logic [mtpa_pkg::COUNT_W-1:0]        slot_count,
    output logic [mtpa_pkg::TEMP_W-1:0]         slot_temp_0,
    output logic [mtpa_pkg::TEMP_W-1:0]         slot_temp_1,
    output logic [mtpa_pkg::TEMP_W-1:0]         slot_temp_2,
    output logic [mtpa_pkg::TEMP_W-1:0]         slot_temp_3,
    output logic [3:0]                          slot_valid_mask,
    output logic [mtpa_pkg::TEMP_W-1:0]         hottest_temp,
    output logic                                hottest_valid
);

    import mtpa_pkg::*;

    // Configuration register
    topo_t topo_reg;

    // Input stage
    logic                s1_valid_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [WORD_W-1:0]   s1_validity_reg;
    logic [WORD_W-1:0]   s1_word_reg [4];
    logic                s1_first_reg;

    // Running hottest state
    logic [TEMP_W-1:0]   hot_reg;
    logic                hot_vld_reg;
    logic [TEMP_W-1:0]   hot_next;
    logic                hot_vld_next;

    // Result stage
    logic                out_valid_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [TEMP_W-1:0]   temp_reg [4];
    logic [3:0]          mask_reg;

    // Combinational results
    logic                advance;
    logic                standard;
    logic [LIMIT_W-1:0]  limit;
    logic                in_range;
    logic                part_ok;
    logic [BASE_W-1:0]   base_next;
    logic [COUNT_W-1:0]  count_next;
    slot_t               dec   [4];
    slot_t               slot  [4];
    logic [3:0]          mask_next;
    logic [TEMP_W-1:0]   prior_hot;
    logic [TEMP_W-1:0]   max_a;
    logic [TEMP_W-1:0]   max_b;

    assign cfg_ready = 1'b1;

    // Handshake: result register frees up when empty or taken
    assign advance  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // Topology decode
    always_comb
    begin
        unique case (topo_reg)
            TOPO_STANDARD:
            begin
                standard = 1'b1;
                limit    = LIMIT_W'(MAX_PARTITIONS);
            end
            TOPO_CLAMSHELL:
            begin
                standard = 1'b0;
                limit    = LIMIT_W'(CLAMSHELL_LIMIT);
            end
            TOPO_UNKNOWN, TOPO_RESERVED:
            begin
                standard = 1'b0;
                limit    = LIMIT_W'(MAX_PARTITIONS);
            end
            default:
            begin
                standard = 1'b0;
                limit    = LIMIT_W'(MAX_PARTITIONS);
            end
        endcase
    end

    assign in_range = LIMIT_W'(s1_idx_reg) < limit;
    assign part_ok  = in_range && word_usable(s1_validity_reg);

    // Slot base and count
    always_comb
    begin
        if (!in_range)
        begin
            count_next = '0;
            base_next  = '0;
        end
        else if (standard)
        begin
            count_next = SLOTS_PAIRED;
            base_next  = BASE_W'({s1_idx_reg, 1'b0});
        end
        else
        begin
            count_next = SLOTS_FULL;
            base_next  = BASE_W'({s1_idx_reg, 2'b00});
        end
    end

    // Word decode and slot mapping
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            dec[i] = decode_word(s1_validity_reg[VALID_SHIFT + i], s1_word_reg[i]);

        if (!part_ok)
        begin
            for (int i = 0; i < 4; i++)
                slot[i] = '0;
        end
        else if (standard)
        begin
            slot[0] = pair_max(dec[0], dec[2]);
            slot[1] = pair_max(dec[1], dec[3]);
            slot[2] = '0;
            slot[3] = '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                slot[i] = dec[i];
        end

        for (int i = 0; i < 4; i++)
            mask_next[i] = slot[i].vld;
    end

    // Running hottest fold; invalid slots and a cleared state read as zero
    assign prior_hot    = s1_first_reg ? '0 : hot_reg;
    assign max_a        = max2(slot[0].temp, slot[1].temp);
    assign max_b        = max2(slot[2].temp, slot[3].temp);
    assign hot_next     = max2(prior_hot, max2(max_a, max_b));
    assign hot_vld_next = (!s1_first_reg && hot_vld_reg) || (|mask_next);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            topo_reg <= TOPO_UNKNOWN;
        else if (cfg_valid && cfg_ready)
            topo_reg <= topo_t'(topology);
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_idx_reg      <= partition_index;
            s1_validity_reg <= validity_word;
            s1_word_reg[0]  <= data_word_0;
            s1_word_reg[1]  <= data_word_1;
            s1_word_reg[2]  <= data_word_2;
            s1_word_reg[3]  <= data_word_3;
            s1_first_reg    <= first_of_pass;
        end
    end

    // Running hottest state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_reg       <= '0;
            hot_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                hot_reg     <= hot_next;
                hot_vld_reg <= hot_vld_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            base_reg  <= base_next;
            count_reg <= count_next;
            mask_reg  <= mask_next;
            for (int i = 0; i < 4; i++)
                temp_reg[i] <= slot[i].temp;
        end
    end

    assign out_valid       = out_valid_reg;
    assign slot_base       = base_reg;
    assign slot_count      = count_reg;
    assign slot_temp_0     = temp_reg[0];
    assign slot_temp_1     = temp_reg[1];
    assign slot_temp_2     = temp_reg[2];
    assign slot_temp_3     = temp_reg[3];
    assign slot_valid_mask = mask_reg;
    assign hottest_temp    = hot_reg;
    assign hottest_valid   = hot_vld_reg;

endmodule

`default_nettype wire

/* rtl/mtpa_checker.sv */
`default_nettype none

module mtpa_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [5:0]  slot_base,
    input wire logic [2:0]  slot_count,
    input wire logic [16:0] slot_temp_0,
    input wire logic [16:0] slot_temp_1,
    input wire logic [3:0]  slot_valid_mask,
    input wire logic [16:0] hottest_temp,
    input wire logic        hottest_valid
);

    // A stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot_valid_mask)
            && $stable(hottest_temp) && $stable(slot_base))
        else $error("result changed while stalled");

    // An ignored partition reports nothing
    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_count == 3'd0 |-> slot_valid_mask == 4'd0 && slot_base == 6'd0)
        else $error("ignored partition reported slots");

    // Any valid slot makes the pass hottest valid
    a_hot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hottest_valid |-> slot_valid_mask == 4'd0 && hottest_temp == 17'd0)
        else $error("hottest not valid with valid slots");

    // Hottest covers slots 0 and 1 of this partition
    a_hot_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_valid_mask[0] |-> slot_temp_0 <= hottest_temp)
        else $error("slot 0 hotter than hottest");

    a_hot_cover1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_valid_mask[1] |-> slot_temp_1 <= hottest_temp)
        else $error("slot 1 hotter than hottest");

endmodule

bind memory_thermal_partition_aggregator_unit mtpa_checker u_mtpa_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slot_base       (slot_base),
    .slot_count      (slot_count),
    .slot_temp_0     (slot_temp_0),
    .slot_temp_1     (slot_temp_1),
    .slot_valid_mask (slot_valid_mask),
    .hottest_temp    (hottest_temp),
    .hottest_valid   (hottest_valid)
);

`default_nettype wire
